>>> sv/hcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_pkg: shared types and constants of the Hill cipher block
// Payload structs, register indexes, the MAC control bundle and the small
// mod-26 helper functions used across the block.
// ----------------------------------------------------------------------------
package hcb_pkg;

  // Letter alphabet size and the pad letter X.
  localparam logic [4:0] MOD_BASE   = 5'd26;
  localparam logic [4:0] PAD_LETTER = 5'd23;

  // Configuration register indexes.
  localparam logic [2:0] REG_KEY_ROW0 = 3'd0;
  localparam logic [2:0] REG_KEY_ROW1 = 3'd1;
  localparam logic [2:0] REG_KEY_ROW2 = 3'd2;
  localparam logic [2:0] REG_KEY_ROW3 = 3'd3;
  localparam logic [2:0] REG_DECRYPT  = 3'd4;

  localparam int KEY_ROW_W = 20;

  // Input request payload.
  typedef struct packed {
    logic [4:0] letter_in;
    logic       message_end;
  } in_item_t;

  // Result request payload.
  typedef struct packed {
    logic [4:0] letter_out;
    logic       block_last;
    logic       key_error;
  } out_item_t;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic en;   // update the accumulator this cycle
    logic clr;  // start from zero instead of the held sum
  } mac_ctrl_t;

  // Reduce a 5-bit value (0..31) into 0..25.
  function automatic logic [4:0] red5(input logic [4:0] v);
    logic [4:0] r;
    r = (v >= MOD_BASE) ? (v - MOD_BASE) : v;
    return r;
  endfunction

  // Additive inverse mod 26 of a reduced value.
  function automatic logic [4:0] neg26(input logic [4:0] v);
    logic [4:0] r;
    r = (v == 5'd0) ? 5'd0 : (MOD_BASE - v);
    return r;
  endfunction

  // Reduce a value below 832 into 0..25 by five compare-and-subtract steps.
  function automatic logic [4:0] mod26_w10(input logic [9:0] v);
    logic [9:0] r;
    logic [9:0] m;
    r = v;
    for (int i = 4; i >= 0; i--) begin
      m = {5'd0, MOD_BASE} << i;
      if (r >= m) begin
        r = r - m;
      end
    end
    return r[4:0];
  endfunction

  // Multiplicative inverse mod 26, zero where none exists.
  function automatic logic [4:0] inv_mod26(input logic [4:0] d);
    logic [4:0] r;
    unique case (d)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/hcb_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_mac: shared mod-26 multiply-accumulate unit
// Each enabled cycle forms (acc + x * y) mod 26, or (x * y) mod 26 when the
// clear bit is set, and holds the result in the accumulator.
// ----------------------------------------------------------------------------
module hcb_mac (
  input  logic              clk,
  input  logic              rst_n,
  input  hcb_pkg::mac_ctrl_t ctrl,
  input  logic [4:0]        x,
  input  logic [4:0]        y,
  output logic [4:0]        acc
);

  logic [4:0] acc_r;
  logic [4:0] acc_nxt;
  logic [9:0] prod;
  logic [9:0] sum;

  // Product plus the running sum stays below 651.
  always_comb begin
    prod    = {5'd0, x} * {5'd0, y};
    sum     = prod + {5'd0, (ctrl.clr ? 5'd0 : acc_r)};
    acc_nxt = hcb_pkg::mod26_w10(sum);
  end

  // Accumulator register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 5'd0;
    end else if (ctrl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

>>> sv/hcb_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_store: letter block buffer
// Collects reduced letters into one block, flags when a request closes the
// block, and reads back the pad letter for places the block never filled.
// ----------------------------------------------------------------------------
module hcb_store #(
  parameter int KEY_N = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [4:0]                   wr_letter,
  input  logic                         wr_end,
  output logic                         close,
  input  logic [$clog2(KEY_N)-1:0]     rd_idx,
  output logic [4:0]                   rd_letter
);

  localparam int KW = $clog2(KEY_N);
  localparam int CW = $clog2(KEY_N + 1);

  logic [4:0]    store_r [KEY_N];
  logic [KW-1:0] fill_r;
  logic [KW-1:0] fill_nxt;
  logic [CW-1:0] blk_fill_r;
  logic [CW-1:0] blk_fill_nxt;

  // A block closes when it is full or the message ends.
  always_comb begin
    close        = wr_end || (fill_r == KW'(KEY_N - 1));
    fill_nxt     = fill_r;
    blk_fill_nxt = blk_fill_r;
    if (wr_en) begin
      if (close) begin
        fill_nxt     = '0;
        blk_fill_nxt = CW'(fill_r) + CW'(1);
      end else begin
        fill_nxt = fill_r + KW'(1);
      end
    end
  end

  // Fill counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      blk_fill_r <= '0;
    end else begin
      fill_r     <= fill_nxt;
      blk_fill_r <= blk_fill_nxt;
    end
  end

  // Letter storage, written at the fill position.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[fill_r] <= hcb_pkg::red5(wr_letter);
    end
  end

  // Places past the real letters of the closed block read as X.
  assign rd_letter = (CW'(rd_idx) < blk_fill_r) ? store_r[rd_idx] : hcb_pkg::PAD_LETTER;

endmodule

>>> sv/hill_cipher_block_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_cipher_block_core: Hill cipher over letter indices
// Buffers KEY_N letters, multiplies the block by the key (or by the 2x2
// modular inverse in decrypt mode) mod 26, and emits the cipher letters.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    hcb_pkg::in_item_t
//   out_     output     out_valid / out_ready  hcb_pkg::out_item_t
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A letter that leaves its block open is only stored. A closing letter starts
// the sequencer: in decrypt mode it first forms the determinant, checks it
// and forms the 2x2 inverse; each output letter is then the sum of KEY_N
// products through the single mod-26 multiply-accumulate unit, followed by
// an emit step. A rejected decrypt (KEY_N other than 2, or a determinant
// with no inverse) emits the stored letters with the key error flag set.
// Reset is synchronous and clears the key, the mode and all control state.
// A stalled output holds the sequencer in its emit step; the final letter of
// a block sits in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
module hill_cipher_block_core #(
  parameter int KEY_N = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hcb_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hcb_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [19:0]         cfg_data
);

  localparam int KW = $clog2(KEY_N);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DET  = 6'b000010,
    ST_CHK  = 6'b000100,
    ST_INV  = 6'b001000,
    ST_MUL  = 6'b010000,
    ST_EMIT = 6'b100000
  } seq_state_t;

  seq_state_t state_r, state_nxt;
  logic [KW-1:0] j_r, j_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [2:0]    step_r, step_nxt;
  logic          err_r, err_nxt;
  logic [4:0]    inv_r, inv_nxt;
  logic [4:0]    dm_r [4];

  logic [hcb_pkg::KEY_ROW_W-1:0] key_row_r [4];
  logic                          decrypt_r;

  logic               out_valid_r, out_valid_nxt;
  hcb_pkg::out_item_t out_data_r, out_data_nxt;

  hcb_pkg::mac_ctrl_t mac_ctrl;
  logic [4:0]         mac_x, mac_y, mac_acc;

  logic          accept;
  logic          close;
  logic [KW-1:0] rd_idx;
  logic [4:0]    rd_letter;
  logic          out_free;
  logic          emit_load;
  logic          j_last;
  logic          k_last;
  logic          dm_wr;
  logic [1:0]    dm_wr_idx;

  logic [hcb_pkg::KEY_ROW_W-1:0] key_sel;
  logic [4:0] key_coef;
  logic [4:0] ka, kb, kc, kd;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        key_row_r[i] <= '0;
      end
      decrypt_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hcb_pkg::REG_KEY_ROW0: key_row_r[0] <= cfg_data;
        hcb_pkg::REG_KEY_ROW1: key_row_r[1] <= cfg_data;
        hcb_pkg::REG_KEY_ROW2: key_row_r[2] <= cfg_data;
        hcb_pkg::REG_KEY_ROW3: key_row_r[3] <= cfg_data;
        hcb_pkg::REG_DECRYPT:  decrypt_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Block buffer.
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign rd_idx   = (state_r == ST_EMIT) ? j_r : k_r;

  hcb_store #(.KEY_N(KEY_N)) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (accept),
    .wr_letter (in_data.letter_in),
    .wr_end    (in_data.message_end),
    .close     (close),
    .rd_idx    (rd_idx),
    .rd_letter (rd_letter)
  );

  // Key entries: the 2x2 corner for the inverse, entry (k, j) for the product.
  always_comb begin
    ka       = hcb_pkg::red5(key_row_r[0][4:0]);
    kb       = hcb_pkg::red5(key_row_r[0][9:5]);
    kc       = hcb_pkg::red5(key_row_r[1][4:0]);
    kd       = hcb_pkg::red5(key_row_r[1][9:5]);
    key_sel  = key_row_r[2'(k_r)];
    key_coef = hcb_pkg::red5(key_sel[5*int'(j_r) +: 5]);
  end

  // Operand selection for the shared unit.
  always_comb begin
    mac_ctrl = '0;
    mac_x    = 5'd0;
    mac_y    = 5'd0;
    unique case (state_r)
      ST_DET: begin
        mac_ctrl.en  = 1'b1;
        mac_ctrl.clr = (step_r == 3'd0);
        mac_x        = (step_r == 3'd0) ? ka : hcb_pkg::neg26(kb);
        mac_y        = (step_r == 3'd0) ? kd : kc;
      end
      ST_INV: begin
        mac_ctrl.en  = (step_r < 3'd4);
        mac_ctrl.clr = 1'b1;
        mac_y        = inv_r;
        unique case (step_r[1:0])
          2'd0: mac_x = kd;
          2'd1: mac_x = hcb_pkg::neg26(kb);
          2'd2: mac_x = hcb_pkg::neg26(kc);
          2'd3: mac_x = ka;
          default: mac_x = 5'd0;
        endcase
      end
      ST_MUL: begin
        mac_ctrl.en  = 1'b1;
        mac_ctrl.clr = (k_r == '0);
        mac_x        = rd_letter;
        mac_y        = decrypt_r ? dm_r[{k_r[0], j_r[0]}] : key_coef;
      end
      default: ;
    endcase
  end

  hcb_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .x     (mac_x),
    .y     (mac_y),
    .acc   (mac_acc)
  );

  // Sequencer and output register.
  assign out_free  = !out_valid_r || out_ready;
  assign j_last    = (j_r == KW'(KEY_N - 1));
  assign k_last    = (k_r == KW'(KEY_N - 1));
  assign emit_load = (state_r == ST_EMIT) && out_free;

  always_comb begin
    state_nxt     = state_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    step_nxt      = step_r;
    err_nxt       = err_r;
    inv_nxt       = inv_r;
    dm_wr         = 1'b0;
    dm_wr_idx     = 2'(step_r - 3'd1);
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && close) begin
          j_nxt    = '0;
          k_nxt    = '0;
          step_nxt = 3'd0;
          err_nxt  = 1'b0;
          if (decrypt_r) begin
            if (KEY_N != 2) begin
              err_nxt   = 1'b1;
              state_nxt = ST_EMIT;
            end else begin
              state_nxt = ST_DET;
            end
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_DET: begin
        step_nxt = step_r + 3'd1;
        if (step_r != 3'd0) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        inv_nxt  = hcb_pkg::inv_mod26(mac_acc);
        step_nxt = 3'd0;
        if (inv_nxt == 5'd0) begin
          err_nxt   = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_INV;
        end
      end
      ST_INV: begin
        // Each inverse entry is captured from the accumulator in the cycle after it is formed.
        dm_wr    = (step_r != 3'd0);
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd4) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (k_last) begin
          state_nxt = ST_EMIT;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.letter_out = err_r ? rd_letter : mac_acc;
          out_data_nxt.block_last = j_last;
          out_data_nxt.key_error  = err_r;
          if (j_last) begin
            state_nxt = ST_IDLE;
          end else begin
            j_nxt     = j_r + KW'(1);
            k_nxt     = '0;
            state_nxt = err_r ? ST_EMIT : ST_MUL;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      j_r         <= '0;
      k_r         <= '0;
      step_r      <= 3'd0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      step_r      <= step_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: inverse factor, inverse matrix, result.
  always_ff @(posedge clk) begin
    inv_r      <= inv_nxt;
    out_data_r <= out_data_nxt;
    if (dm_wr) begin
      dm_r[dm_wr_idx] <= mac_acc;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // The accumulator always holds a reduced residue.
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    mac_acc < hcb_pkg::MOD_BASE)
    else $error("accumulator left the range 0 to 25");

  // A new request is taken only once the pending result ends its block.
  a_accept_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && out_valid_r) |-> out_data_r.block_last)
    else $error("request accepted while a block is still being emitted");

  // Handing over the last letter of a block frees the input at once.
  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_load && j_last) |=> in_ready)
    else $error("input not ready after the last letter of a block");
`endif

endmodule
